### hdl/sbgr_pkg.sv
// shared types and constants of the signed bar graph page renderer
`timescale 1ns / 1ps
package sbgr_pkg;

	localparam int BAR_COUNT     = 4;
	localparam int BAR_IDX_W     = 2;
	localparam int VALUE_W       = 16;
	localparam int SCALE_W       = 15;
	localparam int BAR_LEN_W     = 6;
	localparam int STEP_W        = 3;
	localparam int NUM_W         = SCALE_W + BAR_LEN_W;
	localparam int DVS_W         = SCALE_W + BAR_LEN_W - 1;
	localparam int PAGE_W        = 3;
	localparam int COL_W         = 7;
	localparam int ROW_W         = 6;
	localparam int BYTE_W        = 8;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = 1;
	localparam int QCNT_W        = 2;

	localparam int BAR_MAX       = 60;
	localparam int CENTER_COLUMN = 63;
	localparam int AXIS_LO       = 2;
	localparam int AXIS_HI       = 125;
	localparam int BRAKE_LO      = 112;
	localparam int BRAKE_HI      = 126;
	localparam int BRAKE_ROW_A   = 2;
	localparam int BRAKE_ROW_B   = 3;
	localparam int BAR_BASE_OFF  = 8;
	localparam int BAR_HALF      = 3;

	localparam logic [SCALE_W-1:0] SCALE_RST_0 = 15'd400;
	localparam logic [SCALE_W-1:0] SCALE_RST_1 = 15'd400;
	localparam logic [SCALE_W-1:0] SCALE_RST_2 = 15'd300;
	localparam logic [SCALE_W-1:0] SCALE_RST_3 = 15'd1000;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic                                 is_read;
		logic [BAR_COUNT-1:0][VALUE_W-1:0]    mag;
		logic [BAR_COUNT-1:0]                 neg;
		logic                                 brake;
		logic [PAGE_W-1:0]                    page;
		logic [COL_W-1:0]                     column;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

endpackage

### hdl/sbgr_front.sv
// front end: takes commands, classifies them and queues them for the back end
`timescale 1ns / 1ps
module sbgr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] amps_a,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] amps_b,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] target_speed,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] actual_speed,
	input  logic                              brake,
	input  logic [sbgr_pkg::PAGE_W-1:0]       page,
	input  logic [sbgr_pkg::COL_W-1:0]        column,
	output logic                              head_valid,
	output sbgr_pkg::entry_t                  head,
	input  logic                              pop
);

	sbgr_pkg::entry_t                  entries_q [sbgr_pkg::QUEUE_DEPTH];
	logic [sbgr_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sbgr_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sbgr_pkg::QCNT_W-1:0]       count_q;
	logic                              push;
	sbgr_pkg::entry_t                  entry_in;
	logic [sbgr_pkg::BAR_COUNT-1:0][sbgr_pkg::VALUE_W-1:0] vals;

	assign busy       = (count_q == sbgr_pkg::QCNT_W'(sbgr_pkg::QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	assign vals[0] = amps_a;
	assign vals[1] = amps_b;
	assign vals[2] = target_speed;
	assign vals[3] = actual_speed;

	// magnitude as unsigned, so the most negative value maps to 32768
	always_comb begin
		entry_in.is_read = (op == sbgr_pkg::OP_READ);
		for (int i = 0; i < sbgr_pkg::BAR_COUNT; i++) begin
			entry_in.neg[i] = vals[i][sbgr_pkg::VALUE_W-1];
			entry_in.mag[i] = vals[i][sbgr_pkg::VALUE_W-1] ?
				sbgr_pkg::VALUE_W'(~vals[i] + 16'd1) : vals[i];
		end
		entry_in.brake  = brake;
		entry_in.page   = page;
		entry_in.column = column;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/sbgr_back.sv
// back end: scale registers, bar length divider, bar state and byte renderer
`timescale 1ns / 1ps
module sbgr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [sbgr_pkg::BAR_IDX_W-1:0]    wr_index,
	input  logic [sbgr_pkg::SCALE_W-1:0]      wr_data,
	input  logic                              head_valid,
	input  sbgr_pkg::entry_t                  head,
	output logic                              pop,
	output logic                              done,
	output logic [sbgr_pkg::BYTE_W-1:0]       pixel_byte
);

	sbgr_pkg::state_t                  state_q;
	logic [sbgr_pkg::SCALE_W-1:0]      scale_q [sbgr_pkg::BAR_COUNT];
	logic [sbgr_pkg::BAR_LEN_W-1:0]    bar_len_q [sbgr_pkg::BAR_COUNT];
	logic [sbgr_pkg::BAR_COUNT-1:0]    bar_neg_q;
	logic                              brake_q;
	logic                              heartbeat_q;
	logic [sbgr_pkg::BAR_IDX_W-1:0]    bar_q;
	logic [sbgr_pkg::STEP_W-1:0]       step_q;
	logic [sbgr_pkg::NUM_W-1:0]        rem_q;
	logic [sbgr_pkg::DVS_W-1:0]        dvs_q;
	logic [sbgr_pkg::BAR_LEN_W-1:0]    quot_q;
	logic                              done_q;
	logic [sbgr_pkg::BYTE_W-1:0]       byte_q;

	logic [sbgr_pkg::SCALE_W-1:0]      cur_scale;
	logic [sbgr_pkg::VALUE_W-1:0]      cur_mag;
	logic [sbgr_pkg::SCALE_W-1:0]      clamped;
	logic [sbgr_pkg::NUM_W-1:0]        numer;
	logic                              ge;
	logic [sbgr_pkg::BAR_LEN_W-1:0]    quot_next;
	logic                              last_step;
	logic [sbgr_pkg::BYTE_W-1:0]       byte_d;

	assign cur_scale = scale_q[bar_q];
	assign cur_mag   = head.mag[bar_q];
	assign clamped   = (cur_mag > sbgr_pkg::VALUE_W'(cur_scale)) ? cur_scale :
		sbgr_pkg::SCALE_W'(cur_mag);
	assign numer     = sbgr_pkg::NUM_W'(clamped) * sbgr_pkg::NUM_W'(sbgr_pkg::BAR_MAX);
	assign ge        = (rem_q >= sbgr_pkg::NUM_W'(dvs_q));
	assign quot_next = {quot_q[sbgr_pkg::BAR_LEN_W-2:0], ge};
	assign last_step = (step_q == sbgr_pkg::STEP_W'(sbgr_pkg::BAR_LEN_W - 1));

	always_comb begin
		pop = 1'b0;
		case (state_q)
			sbgr_pkg::ST_IDLE: pop = head_valid && head.is_read;
			sbgr_pkg::ST_LOAD: pop = 1'b0;
			sbgr_pkg::ST_DIV:  pop = last_step &&
				(bar_q == sbgr_pkg::BAR_IDX_W'(sbgr_pkg::BAR_COUNT - 1));
			default:           pop = 1'b0;
		endcase
	end

	// one display byte: eight rows of the page at one column
	always_comb begin
		logic [sbgr_pkg::ROW_W-1:0]     y;
		logic [3:0]                     off;
		logic [sbgr_pkg::BAR_LEN_W-1:0] len;
		logic [7:0]                     x8;
		logic                           on;
		logic                           in_band;
		byte_d = '0;
		x8     = {1'b0, head.column};
		for (int i = 0; i < sbgr_pkg::BYTE_W; i++) begin
			y   = {head.page, 3'(i)};
			off = y[3:0];
			len = bar_len_q[y[5:4]];
			on  = 1'b0;
			if (x8 == 8'(sbgr_pkg::CENTER_COLUMN)) begin
				on = 1'b1;
			end
			if (heartbeat_q && x8 == 8'd0 && y == '0) begin
				on = 1'b1;
			end
			if (brake_q && (y == 6'(sbgr_pkg::BRAKE_ROW_A) || y == 6'(sbgr_pkg::BRAKE_ROW_B))
					&& x8 >= 8'(sbgr_pkg::BRAKE_LO) && x8 <= 8'(sbgr_pkg::BRAKE_HI)) begin
				on = 1'b1;
			end
			if (off == 4'(sbgr_pkg::BAR_BASE_OFF) && x8 >= 8'(sbgr_pkg::AXIS_LO)
					&& x8 <= 8'(sbgr_pkg::AXIS_HI)) begin
				on = 1'b1;
			end
			in_band = (off >= 4'(sbgr_pkg::BAR_BASE_OFF - sbgr_pkg::BAR_HALF))
				&& (off <= 4'(sbgr_pkg::BAR_BASE_OFF + sbgr_pkg::BAR_HALF)) && (len != '0);
			if (in_band) begin
				if (!bar_neg_q[y[5:4]]) begin
					if (x8 > 8'(sbgr_pkg::CENTER_COLUMN)
							&& (x8 - 8'(sbgr_pkg::CENTER_COLUMN)) <= 8'(len)) begin
						on = 1'b1;
					end
				end else begin
					if (x8 < 8'(sbgr_pkg::CENTER_COLUMN)
							&& (x8 + 8'(len)) >= 8'(sbgr_pkg::CENTER_COLUMN)) begin
						on = 1'b1;
					end
				end
			end
			byte_d[i] = on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q[0] <= sbgr_pkg::SCALE_RST_0;
			scale_q[1] <= sbgr_pkg::SCALE_RST_1;
			scale_q[2] <= sbgr_pkg::SCALE_RST_2;
			scale_q[3] <= sbgr_pkg::SCALE_RST_3;
		end else if (wr_en) begin
			scale_q[wr_index] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		case (state_q)
			sbgr_pkg::ST_LOAD: begin
				rem_q  <= numer;
				dvs_q  <= {cur_scale, 5'd0};
				quot_q <= '0;
			end
			sbgr_pkg::ST_DIV: begin
				if (ge) begin
					rem_q <= rem_q - sbgr_pkg::NUM_W'(dvs_q);
				end
				dvs_q  <= dvs_q >> 1;
				quot_q <= quot_next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbgr_pkg::ST_IDLE;
			bar_q       <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
			brake_q     <= 1'b0;
			heartbeat_q <= 1'b0;
			bar_neg_q   <= '0;
			for (int i = 0; i < sbgr_pkg::BAR_COUNT; i++) begin
				bar_len_q[i] <= '0;
			end
		end else begin
			done_q <= (state_q == sbgr_pkg::ST_IDLE) && head_valid && head.is_read;
			case (state_q)
				sbgr_pkg::ST_IDLE: begin
					if (head_valid && !head.is_read) begin
						bar_q   <= '0;
						state_q <= sbgr_pkg::ST_LOAD;
					end
				end
				sbgr_pkg::ST_LOAD: begin
					step_q  <= '0;
					state_q <= sbgr_pkg::ST_DIV;
				end
				sbgr_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						bar_len_q[bar_q] <= (cur_scale == '0) ? '0 : quot_next;
						bar_neg_q[bar_q] <= head.neg[bar_q];
						if (bar_q == sbgr_pkg::BAR_IDX_W'(sbgr_pkg::BAR_COUNT - 1)) begin
							brake_q     <= head.brake;
							heartbeat_q <= !heartbeat_q;
							state_q     <= sbgr_pkg::ST_IDLE;
						end else begin
							bar_q   <= bar_q + 1'b1;
							state_q <= sbgr_pkg::ST_LOAD;
						end
					end
				end
				default: state_q <= sbgr_pkg::ST_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign pixel_byte = byte_q;

	a_done_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == sbgr_pkg::ST_IDLE && head_valid && head.is_read))
		else $error("result strobe without a read command");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbgr_pkg::ST_DIV) |-> (step_q < sbgr_pkg::STEP_W'(sbgr_pkg::BAR_LEN_W)))
		else $error("divider step out of range");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bar_len_q[0] <= sbgr_pkg::BAR_LEN_W'(sbgr_pkg::BAR_MAX))
		&& (bar_len_q[1] <= sbgr_pkg::BAR_LEN_W'(sbgr_pkg::BAR_MAX))
		&& (bar_len_q[2] <= sbgr_pkg::BAR_LEN_W'(sbgr_pkg::BAR_MAX))
		&& (bar_len_q[3] <= sbgr_pkg::BAR_LEN_W'(sbgr_pkg::BAR_MAX)))
		else $error("bar length above full length");

endmodule

### hdl/signed_bar_graph_page_renderer_unit.sv
// top level of the signed bar graph page renderer
// read: queued, then the result strobe is registered; one read per cycle when idle
// frame: no result; per bar in turn the divider loads, then forms quotient bits
// a two-entry command queue takes commands while a frame is divided
// the receiver cannot stall; busy is high only while the command queue is full
// async reset clears the queue, bars, brake, heartbeat and restores scale defaults
`timescale 1ns / 1ps
module signed_bar_graph_page_renderer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] amps_a,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] amps_b,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] target_speed,
	input  logic signed [sbgr_pkg::VALUE_W-1:0] actual_speed,
	input  logic                              brake,
	input  logic [sbgr_pkg::PAGE_W-1:0]       page,
	input  logic [sbgr_pkg::COL_W-1:0]        column,
	input  logic                              wr_en,
	input  logic [sbgr_pkg::BAR_IDX_W-1:0]    wr_index,
	input  logic [sbgr_pkg::SCALE_W-1:0]      wr_data,
	output logic                              done,
	output logic [sbgr_pkg::BYTE_W-1:0]       pixel_byte
);

	logic             head_valid;
	sbgr_pkg::entry_t head;
	logic             pop;

	sbgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.amps_a       (amps_a),
		.amps_b       (amps_b),
		.target_speed (target_speed),
		.actual_speed (actual_speed),
		.brake        (brake),
		.page         (page),
		.column       (column),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	sbgr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.pixel_byte (pixel_byte)
	);

endmodule
